@@ rtl/assert_macros.svh @@
// Assertion macros shared by the EMA block RTL.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define EMA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define EMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define EMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ema_pkg.sv @@
// Shared constants, state type and controller/datapath interface structs
// for the EMA block. No dependencies.
`timescale 1ns / 1ps

package ema_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int PRICE_W     = 32;
  localparam int PERIOD_W    = 10;
  localparam int CNT_W       = PERIOD_W + 1;
  localparam int SUM_W       = 42;
  localparam int ALPHA_W     = FRAC_BITS + 1;
  localparam int DIV_W       = CNT_W;
  localparam int PROD_W      = PRICE_W + ALPHA_W;
  localparam int STEP_W      = $clog2(SUM_W + 1);
  // alpha dividend is 2 << FRAC_BITS, FRAC_BITS + 2 bits wide
  localparam int ALPHA_STEPS = FRAC_BITS + 2;
  localparam int PERIOD_RST  = 14;
  localparam int PERIOD_MAX  = (1 << PERIOD_W) - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_SEED,
    ST_DIV_ALPHA,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load_px;
    logic accum;
    logic div_start;
    logic div_alpha;
    logic seed_load;
    logic mul;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic seen_lt;
    logic seen_eq;
    logic div_busy;
  } sts_t;

endpackage

@@ rtl/ema_with_sma_seed.sv @@
// Seed-phase prices give no word. An update runs from accept through an 18-step
// serial divide for alpha, then multiply and update, to m_axis_tvalid; the seeding
// price first runs a 42-step seed divide.
// A new price is taken only once the last one is through, and a held output
// word blocks the update.
// Reset (rst, synchronous, active high): period 14, sum, count and average zero.
`timescale 1ns / 1ps

module ema_with_sma_seed (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ema_pkg::PRICE_W-1:0]  s_axis_tdata,   // [31:0] price
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [2*ema_pkg::PRICE_W-1:0] m_axis_tdata,  // [31:0] price_echo, [63:32] average
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ema_pkg::PERIOD_W-1:0] cfg_data        // period
);

  ema_pkg::cmd_t               cmd;
  ema_pkg::sts_t               sts;
  logic [ema_pkg::PRICE_W-1:0] price_echo;
  logic [ema_pkg::PRICE_W-1:0] average;

  assign cfg_ready = 1'b1;

  ema_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  ema_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .price_in   (s_axis_tdata),
    .sts        (sts),
    .price_echo (price_echo),
    .average    (average)
  );

  assign m_axis_tdata = {average, price_echo};

endmodule

@@ rtl/ema_dp.sv @@
// EMA datapath: period register, seed accumulator, serial divider,
// multiplier and average update. Uses ema_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ema_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [ema_pkg::PERIOD_W-1:0]  cfg_data,
  input  ema_pkg::cmd_t                 cmd,
  input  logic [ema_pkg::PRICE_W-1:0]   price_in,
  output ema_pkg::sts_t                 sts,
  output logic [ema_pkg::PRICE_W-1:0]   price_echo,
  output logic [ema_pkg::PRICE_W-1:0]   average
);

  localparam int DELTA_W = ema_pkg::PROD_W + 1 - ema_pkg::FRAC_BITS;
  localparam int RES_W   = DELTA_W + 1;
  localparam logic [ema_pkg::CNT_W-1:0] SEEN_MAX = ema_pkg::CNT_W'(ema_pkg::PERIOD_MAX + 1);

  logic [ema_pkg::PERIOD_W-1:0] period;
  logic [ema_pkg::CNT_W-1:0]    seen_count;
  logic [ema_pkg::SUM_W-1:0]    seed_sum;
  logic [ema_pkg::PRICE_W-1:0]  avg;
  logic [ema_pkg::STEP_W-1:0]   step_cnt;

  logic [ema_pkg::PRICE_W-1:0]  px;
  logic [ema_pkg::SUM_W-1:0]    div_reg;
  logic [ema_pkg::DIV_W-1:0]    rem;
  logic [ema_pkg::DIV_W-1:0]    divisor;
  logic [ema_pkg::PROD_W-1:0]   prod;
  logic                         prod_neg;

  logic [ema_pkg::PERIOD_W-1:0] eff_p;
  logic [ema_pkg::CNT_W-1:0]    p_ext;
  logic [ema_pkg::DIV_W:0]      trial;
  logic [ema_pkg::DIV_W:0]      trial_sub;
  logic                         ge;
  logic [ema_pkg::PRICE_W-1:0]  seed_q;
  logic [ema_pkg::PRICE_W:0]    diff;
  logic [ema_pkg::PRICE_W:0]    diff_neg;
  logic [ema_pkg::PRICE_W-1:0]  mag;
  logic [ema_pkg::ALPHA_W-1:0]  alpha;
  logic [ema_pkg::PROD_W:0]     prod_rnd;
  logic [DELTA_W-1:0]           delta;
  logic [RES_W-1:0]             res;
  logic [ema_pkg::PRICE_W-1:0]  res_clamp;

  // period zero behaves as period one
  assign eff_p = (period == '0) ? ema_pkg::PERIOD_W'(1) : period;
  assign p_ext = {1'b0, eff_p};

  assign sts.seen_lt  = seen_count < p_ext;
  assign sts.seen_eq  = seen_count == p_ext;
  assign sts.div_busy = step_cnt != '0;

  // restoring divider, one quotient bit per cycle, quotient shifts into div_reg
  assign trial     = {rem, div_reg[ema_pkg::SUM_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = trial >= {1'b0, divisor};

  assign seed_q = (|div_reg[ema_pkg::SUM_W-1:ema_pkg::PRICE_W]) ? '1
                                                               : div_reg[ema_pkg::PRICE_W-1:0];

  assign alpha    = div_reg[ema_pkg::ALPHA_W-1:0];
  assign diff     = {1'b0, px} - {1'b0, avg};
  assign diff_neg = '0 - diff;
  assign mag      = diff[ema_pkg::PRICE_W] ? diff_neg[ema_pkg::PRICE_W-1:0]
                                           : diff[ema_pkg::PRICE_W-1:0];

  // negative deltas round away from zero
  assign prod_rnd = {1'b0, prod} +
                    (prod_neg ? (ema_pkg::PROD_W+1)'((1 << ema_pkg::FRAC_BITS) - 1)
                              : '0);
  assign delta    = prod_rnd[ema_pkg::PROD_W:ema_pkg::FRAC_BITS];
  assign res      = prod_neg ? (RES_W'(avg) - RES_W'(delta))
                             : (RES_W'(avg) + RES_W'(delta));

  always_comb begin
    if (res[RES_W-1]) begin
      res_clamp = '0;
    end else if (|res[RES_W-2:ema_pkg::PRICE_W]) begin
      res_clamp = '1;
    end else begin
      res_clamp = res[ema_pkg::PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= ema_pkg::PERIOD_W'(ema_pkg::PERIOD_RST);
      seen_count <= '0;
      seed_sum   <= '0;
      avg        <= '0;
      step_cnt   <= '0;
    end else begin
      if (cfg_valid) begin
        period <= cfg_data;
      end
      if (cmd.accum) begin
        seed_sum   <= seed_sum + ema_pkg::SUM_W'(px);
        seen_count <= seen_count + 1'b1;
      end
      if (cmd.seed_load) begin
        avg        <= seed_q;
        seen_count <= seen_count + 1'b1;
      end
      if (cmd.upd) begin
        avg <= res_clamp;
      end
      if (cmd.div_start) begin
        step_cnt <= cmd.div_alpha ? ema_pkg::STEP_W'(ema_pkg::ALPHA_STEPS)
                                  : ema_pkg::STEP_W'(ema_pkg::SUM_W);
      end else if (step_cnt != '0) begin
        step_cnt <= step_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      px <= price_in;
    end
    if (cmd.div_start) begin
      div_reg <= cmd.div_alpha ? (ema_pkg::SUM_W'(1) << (ema_pkg::SUM_W - 1)) : seed_sum;
      rem     <= '0;
      divisor <= cmd.div_alpha ? (p_ext + 1'b1) : p_ext;
    end else if (step_cnt != '0) begin
      div_reg <= {div_reg[ema_pkg::SUM_W-2:0], ge};
      rem     <= ge ? trial_sub[ema_pkg::DIV_W-1:0] : trial[ema_pkg::DIV_W-1:0];
    end
    if (cmd.mul) begin
      prod     <= ema_pkg::PROD_W'(mag) * ema_pkg::PROD_W'(alpha);
      prod_neg <= diff[ema_pkg::PRICE_W];
    end
    if (cmd.upd) begin
      price_echo <= px;
      average    <= res_clamp;
    end
  end

  `EMA_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy, "divider did not start")
  `EMA_ASSERT_ALWAYS(a_seen_cap, seen_count <= SEEN_MAX, "seen_count past saturation")
  `EMA_ASSERT_IMPL(a_seed_div_done, cmd.seed_load, !sts.div_busy, "seed taken mid-divide")

endmodule

@@ rtl/ema_ctrl.sv @@
// EMA controller: sequences accumulate, seed divide, alpha divide, multiply
// and update, and owns both stream handshakes. Uses ema_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ema_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  ema_pkg::sts_t sts,
  output ema_pkg::cmd_t cmd
);

  ema_pkg::state_t state, state_next;
  logic            out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ema_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.upd) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ema_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_px = 1'b1;
          state_next  = ema_pkg::ST_CHECK;
        end
      end
      ema_pkg::ST_CHECK: begin
        priority if (sts.seen_lt) begin
          cmd.accum  = 1'b1;
          state_next = ema_pkg::ST_IDLE;
        end else if (sts.seen_eq) begin
          cmd.div_start = 1'b1;
          state_next    = ema_pkg::ST_DIV_SEED;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_alpha = 1'b1;
          state_next    = ema_pkg::ST_DIV_ALPHA;
        end
      end
      ema_pkg::ST_DIV_SEED: begin
        // seed quotient is taken while the alpha divide is launched
        if (!sts.div_busy) begin
          cmd.seed_load = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_alpha = 1'b1;
          state_next    = ema_pkg::ST_DIV_ALPHA;
        end
      end
      ema_pkg::ST_DIV_ALPHA: begin
        if (!sts.div_busy) begin
          cmd.mul    = 1'b1;
          state_next = ema_pkg::ST_MUL;
        end
      end
      ema_pkg::ST_MUL: begin
        state_next = ema_pkg::ST_UPD;
      end
      ema_pkg::ST_UPD: begin
        if (!out_valid || m_axis_tready) begin
          cmd.upd    = 1'b1;
          state_next = ema_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ema_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;

  `EMA_ASSERT_IMPL(a_start_idle_div, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `EMA_ASSERT_IMPL(a_no_overwrite, cmd.upd, !m_axis_tvalid || m_axis_tready, "result overwritten")
  `EMA_ASSERT_IMPL(a_ready_div_idle, s_axis_tready, !sts.div_busy, "ready while divider busy")

endmodule
